// ===== rtl/bstr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstr_pkg
// Shared types and codes of the switch target resolver.
// ----------------------------------------------------------------------------
package bstr_pkg;

  // One input transaction: a switch start or one table word.
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] key;
    logic [15:0]        opcode_offset;
    logic signed [31:0] table_word;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic        result_kind;
    logic [15:0] code_offset;
    logic        took_default;
    logic        malformed;
  } result_t;

  localparam logic [1:0] MODE_TABLE_START  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP_START = 2'd1;
  localparam logic [1:0] MODE_WORD         = 2'd2;
  localparam logic [1:0] MODE_RESERVED     = 2'd3;

  localparam logic KIND_TABLE_START = 1'b0;
  localparam logic KIND_TARGET      = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/bstr_item_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstr_item_if
// Input channel: switch start items and table words with valid/ready.
// ----------------------------------------------------------------------------
interface bstr_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] key;
  logic [15:0]        opcode_offset;
  logic signed [31:0] table_word;

  modport source (output valid, output mode, output key, output opcode_offset,
                  output table_word, input ready);
  modport sink   (input valid, input mode, input key, input opcode_offset,
                  input table_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/bstr_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstr_result_if
// Output channel: table start offsets and resolved branch targets.
// ----------------------------------------------------------------------------
interface bstr_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] code_offset;
  logic        took_default;
  logic        malformed;

  modport source (output valid, output result_kind, output code_offset,
                  output took_default, output malformed, input ready);
  modport sink   (input valid, input result_kind, input code_offset,
                  input took_default, input malformed, output ready);
endinterface
`default_nettype wire

// ===== rtl/bytecode_switch_target_resolver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bytecode_switch_target_resolver
// Resolves the branch target of a tableswitch or lookupswitch.
// ----------------------------------------------------------------------------
// Usage: item_i takes one transaction per cycle while item_i.ready is high.
// A start transaction (mode 0 tableswitch, mode 1 lookupswitch) carries the
// key and the opcode offset and produces a result with the 4-aligned table
// start. Table words (mode 2) follow one per transaction; the word that ends
// the table produces the branch target, or the default target on no hit or a
// bad header. Words outside a switch and mode 3 produce nothing.
// Path: the input register captures a transaction when it is accepted; the
// switch state machine forms the result from it combinationally, and the
// result register loads that result and presents it on result_o. Throughput
// is one transaction per cycle while result_o is not held, set by the single
// pass through the switch state machine between the two registers.
// Stall: while result_o is held, the result register keeps its content, and
// an empty input register takes one more transaction before item_i.ready drops.
// Reset: both registers empty, the switch state idle.
// ----------------------------------------------------------------------------
module bytecode_switch_target_resolver #(
  parameter int unsigned CODE_ADDR_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bstr_item_if.sink     item_i,
  bstr_result_if.source result_o
);

  bstr_pkg::item_t   in_item;
  bstr_pkg::item_t   s1_item;
  logic              s1_valid;
  logic              take;
  logic              core_fire;
  logic              core_valid;
  bstr_pkg::result_t core_res;
  bstr_pkg::result_t out_res;

  assign in_item.mode          = item_i.mode;
  assign in_item.key           = item_i.key;
  assign in_item.opcode_offset = item_i.opcode_offset;
  assign in_item.table_word    = item_i.table_word;

  bstr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_i.valid),
    .ready_o   (item_i.ready),
    .item_i    (in_item),
    .advance_i (take),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  assign core_fire = s1_valid && take;

  bstr_core #(
    .CODE_ADDR_BITS (CODE_ADDR_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (core_fire),
    .item_i      (s1_item),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  bstr_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (core_valid),
    .result_i (core_res),
    .take_o   (take),
    .valid_o  (result_o.valid),
    .ready_i  (result_o.ready),
    .result_o (out_res)
  );

  assign result_o.result_kind  = out_res.result_kind;
  assign result_o.code_offset  = out_res.code_offset;
  assign result_o.took_default = out_res.took_default;
  assign result_o.malformed    = out_res.malformed;

  // A queued transaction must not be lost while the result side stalls.
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !take |=> s1_valid)
    else $error("input stage dropped a transaction under stall");

  // The core only produces a result for a transaction it consumes.
  a_res_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_valid |-> core_fire)
    else $error("result without a consumed transaction");

  // A consumed transaction with a result shows up on the output next cycle.
  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_valid |=> result_o.valid)
    else $error("result lost between core and result register");

  // A table start never reports a default branch.
  a_start_no_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.result_kind == bstr_pkg::KIND_TABLE_START)
      |-> !result_o.took_default)
    else $error("table start result flagged default");

endmodule
`default_nettype wire

// ===== rtl/bstr_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstr_in_reg
// Input register stage; holds one transaction until the core consumes it.
// ----------------------------------------------------------------------------
module bstr_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire bstr_pkg::item_t item_i,
  input  wire logic           advance_i,
  output logic                valid_o,
  output bstr_pkg::item_t     item_o
);

  logic            valid_q;
  bstr_pkg::item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bstr_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstr_core
// Switch state machine: walks the table words and forms the result.
// ----------------------------------------------------------------------------
module bstr_core #(
  parameter int unsigned CODE_ADDR_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire bstr_pkg::item_t item_i,
  output logic                 res_valid_o,
  output bstr_pkg::result_t    res_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DEF    = 3'd1;
  localparam logic [2:0] PH_LOW    = 3'd2;
  localparam logic [2:0] PH_HIGH   = 3'd3;
  localparam logic [2:0] PH_JUMPS  = 3'd4;
  localparam logic [2:0] PH_NPAIRS = 3'd5;
  localparam logic [2:0] PH_PAIRS  = 3'd6;

  localparam logic [33:0] MAX_WORDS = 34'h1FFFF;

  logic [2:0]  phase_q, phase_d;
  logic        is_lookup_q, is_lookup_d;
  logic [31:0] switch_key_q, switch_key_d;
  logic [15:0] switch_base_q, switch_base_d;
  logic [31:0] default_jump_q, default_jump_d;
  logic [31:0] low_bound_q, low_bound_d;
  logic [32:0] key_idx_q, key_idx_d;       // key minus low bound
  logic [16:0] words_left_q, words_left_d;
  logic [16:0] word_index_q, word_index_d;
  logic        pair_matched_q, pair_matched_d;
  logic [31:0] chosen_jump_q, chosen_jump_d;
  logic        take_next_q, take_next_d;

  logic [31:0] w;
  logic [16:0] words_dec;
  logic [16:0] start_off;
  logic [33:0] count;
  logic        hi_lt_lo;
  logic        key_le_hi;
  logic        is_start;
  logic        fin;
  logic        hit;
  logic        bad_hdr;
  logic [31:0] jump;
  logic [33:0] target_sum;
  logic [33:0] off;
  logic [33:0] off_hi;

  assign w         = item_i.table_word;
  assign words_dec = words_left_q - 17'd1;
  assign start_off = ({1'b0, item_i.opcode_offset} + 17'd4) & ~17'd3;
  assign count     = {{2{w[31]}}, w} - {{2{low_bound_q[31]}}, low_bound_q} + 34'd1;
  assign hi_lt_lo  = $signed(w) < $signed(low_bound_q);
  assign key_le_hi = $signed(switch_key_q) <= $signed(w);

  always_comb begin
    phase_d        = phase_q;
    is_lookup_d    = is_lookup_q;
    switch_key_d   = switch_key_q;
    switch_base_d  = switch_base_q;
    default_jump_d = default_jump_q;
    low_bound_d    = low_bound_q;
    key_idx_d      = key_idx_q;
    words_left_d   = words_left_q;
    word_index_d   = word_index_q;
    pair_matched_d = pair_matched_q;
    chosen_jump_d  = chosen_jump_q;
    take_next_d    = take_next_q;
    is_start       = 1'b0;
    fin            = 1'b0;
    hit            = 1'b0;
    bad_hdr        = 1'b0;

    if (fire_i) begin
      unique case (item_i.mode) inside
        bstr_pkg::MODE_TABLE_START, bstr_pkg::MODE_LOOKUP_START: begin
          // A start abandons any switch in progress.
          is_start       = 1'b1;
          is_lookup_d    = (item_i.mode == bstr_pkg::MODE_LOOKUP_START);
          switch_key_d   = item_i.key;
          switch_base_d  = item_i.opcode_offset;
          words_left_d   = '0;
          word_index_d   = '0;
          pair_matched_d = 1'b0;
          chosen_jump_d  = '0;
          take_next_d    = 1'b0;
          phase_d        = PH_DEF;
        end
        bstr_pkg::MODE_WORD: begin
          unique case (phase_q)
            PH_DEF: begin
              default_jump_d = w;
              phase_d        = is_lookup_q ? PH_NPAIRS : PH_LOW;
            end
            PH_LOW: begin
              low_bound_d = w;
              key_idx_d   = {switch_key_q[31], switch_key_q} - {w[31], w};
              phase_d     = PH_HIGH;
            end
            PH_HIGH: begin
              if (hi_lt_lo || ($signed(count) > $signed(MAX_WORDS))) begin
                fin     = 1'b1;
                bad_hdr = 1'b1;
              end else begin
                words_left_d   = count[16:0];
                word_index_d   = '0;
                pair_matched_d = !key_idx_q[32] && key_le_hi;
                phase_d        = PH_JUMPS;
              end
            end
            PH_JUMPS: begin
              if (pair_matched_q && (word_index_q == key_idx_q[16:0])) begin
                chosen_jump_d = w;
              end
              word_index_d = word_index_q + 17'd1;
              words_left_d = words_dec;
              if (words_dec == '0) begin
                fin = 1'b1;
                hit = pair_matched_q;
              end
            end
            PH_NPAIRS: begin
              if (w[31] || (|w[30:16])) begin
                fin     = 1'b1;
                bad_hdr = 1'b1;
              end else if (w[15:0] == '0) begin
                fin = 1'b1;
              end else begin
                words_left_d = {w[15:0], 1'b0};
                word_index_d = '0;
                phase_d      = PH_PAIRS;
              end
            end
            PH_PAIRS: begin
              // Even words are match values, odd words their offsets.
              if (!word_index_q[0]) begin
                take_next_d = !pair_matched_q && (w == switch_key_q);
                if (take_next_d) begin
                  pair_matched_d = 1'b1;
                end
              end else if (take_next_q) begin
                chosen_jump_d = w;
                take_next_d   = 1'b0;
              end
              word_index_d = word_index_q + 17'd1;
              words_left_d = words_dec;
              if (words_dec == '0) begin
                fin = 1'b1;
                hit = pair_matched_d;
              end
            end
            default: begin
            end
          endcase
          if (fin) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign jump       = hit ? chosen_jump_d : default_jump_q;
  assign target_sum = {18'd0, switch_base_q} + {{2{jump[31]}}, jump};
  assign off        = is_start ? {17'd0, start_off} : target_sum;
  // Negative sums have the top bit set, so any bit above the range flags it.
  assign off_hi     = off >> CODE_ADDR_BITS;

  assign res_valid_o        = is_start || fin;
  assign res_o.result_kind  = is_start ? bstr_pkg::KIND_TABLE_START
                                       : bstr_pkg::KIND_TARGET;
  assign res_o.code_offset  = off[15:0];
  assign res_o.took_default = !is_start && !hit;
  assign res_o.malformed    = bad_hdr || (|off_hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      is_lookup_q    <= 1'b0;
      switch_key_q   <= '0;
      switch_base_q  <= '0;
      default_jump_q <= '0;
      low_bound_q    <= '0;
      key_idx_q      <= '0;
      words_left_q   <= '0;
      word_index_q   <= '0;
      pair_matched_q <= 1'b0;
      chosen_jump_q  <= '0;
      take_next_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      is_lookup_q    <= is_lookup_d;
      switch_key_q   <= switch_key_d;
      switch_base_q  <= switch_base_d;
      default_jump_q <= default_jump_d;
      low_bound_q    <= low_bound_d;
      key_idx_q      <= key_idx_d;
      words_left_q   <= words_left_d;
      word_index_q   <= word_index_d;
      pair_matched_q <= pair_matched_d;
      chosen_jump_q  <= chosen_jump_d;
      take_next_q    <= take_next_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bstr_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bstr_out_reg
// Result register; loads when empty or when the receiver takes its content.
// ----------------------------------------------------------------------------
module bstr_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire bstr_pkg::result_t result_i,
  output logic                   take_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output bstr_pkg::result_t      result_o
);

  logic              valid_q;
  bstr_pkg::result_t result_q;

  assign take_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule
`default_nettype wire
